/* rtl/core/swmp_pkg.sv */
// Shared constants and types for the sample window mean and peak block.
`default_nettype none

package swmp_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned CENT_W     = 11;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = 10'd1023;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_SCAN,
    ST_DONE
  } eng_state_e;

endpackage

`default_nettype wire

/* rtl/core/swmp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module swmp_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/swmp_front.sv */
// Input stage: assigns each sample its ring slot and queues it for the engine.
`default_nettype none

module swmp_front import swmp_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [SAMPLE_W-1:0]           sample_i,
  output logic                               job_valid_o,
  input  wire logic                          job_pop_i,
  output logic      [SAMPLE_W-1:0]           job_sample_o,
  output logic      [$clog2(WINDOW_LEN)-1:0] job_slot_o,
  output logic                               job_full_o
);

  localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_LEN - 1);

  logic [IDX_W-1:0]    slot_q, slot_d;
  logic                full_q, full_d;
  logic [SAMPLE_W-1:0] q_sample_q [2];
  logic [IDX_W-1:0]    q_slot_q   [2];
  logic                q_full_q   [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;
  logic                push, pop;

  assign in_stall_o  = (count_q == 2'd2);
  assign job_valid_o = (count_q != 2'd0);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_pop_i && job_valid_o;

  assign job_sample_o = q_sample_q[rd_ptr_q];
  assign job_slot_o   = q_slot_q[rd_ptr_q];
  assign job_full_o   = q_full_q[rd_ptr_q];

  always_comb begin
    slot_d   = slot_q;
    full_d   = full_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      slot_d   = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
      full_d   = full_q || (slot_d == LAST_SLOT);
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= LAST_SLOT;
      full_q   <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      slot_q   <= slot_d;
      full_q   <= full_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_sample_q[wr_ptr_q] <= sample_i;
      q_slot_q[wr_ptr_q]   <= slot_d;
      q_full_q[wr_ptr_q]   <= full_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/swmp_engine.sv */
// Back end: updates the ring and running sum, divides for the mean, scans the window.
`default_nettype none

module swmp_engine import swmp_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          job_valid_i,
  output logic                               job_pop_o,
  input  wire logic [SAMPLE_W-1:0]           job_sample_i,
  input  wire logic [$clog2(WINDOW_LEN)-1:0] job_slot_i,
  input  wire logic                          job_full_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [SAMPLE_W-1:0]           newest_sample_o,
  output logic      [SAMPLE_W-1:0]           window_mean_o,
  output logic signed [CENT_W-1:0]           centered_sample_o,
  output logic      [SAMPLE_W-1:0]           peak_deviation_o,
  output logic      [SAMPLE_W-1:0]           peak_to_peak_o
);

  localparam int unsigned IDX_W       = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W       = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W       = $clog2(WINDOW_LEN * 1023 + 1);
  localparam int unsigned RECIP_SHIFT = SUM_W + IDX_W;
  localparam int unsigned RECIP_W     = SUM_W + 2;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(WINDOW_LEN);
  // The mean is the sum times a rounded-up reciprocal of the window length, which
  // gives the exact truncated quotient for every sum that fits in SUM_W bits.
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
    ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  eng_state_e state_q, state_d;

  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [SAMPLE_W-1:0]  samp_q, samp_d;
  logic [IDX_W-1:0]     slot_q, slot_d;
  logic                 full_q, full_d;
  logic [SAMPLE_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_addr_q, rd_addr_d;
  logic [SAMPLE_W-1:0]  hi_q, hi_d, lo_q, lo_d, dev_q, dev_d;
  logic                 out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]  o_samp_q, o_samp_d, o_mean_q, o_mean_d;
  logic [SAMPLE_W-1:0]  o_dev_q, o_dev_d, o_p2p_q, o_p2p_d;
  logic [CENT_W-1:0]    o_cent_q, o_cent_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SAMPLE_W-1:0]  ram_rdata;
  logic [SAMPLE_W-1:0]  old_val, scan_val, scan_diff;
  logic [PROD_W-1:0]    mean_prod;
  logic                 out_free;

  swmp_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_LEN)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(samp_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign old_val     = full_q ? ram_rdata : '0;
  assign scan_val    = (full_q || (rd_addr_q <= slot_q)) ? ram_rdata : '0;
  assign scan_diff   = (scan_val >= quo_q) ? scan_val - quo_q : quo_q - scan_val;
  assign mean_prod   = PROD_W'(sum_q) * PROD_W'(RECIP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_DIVIDE;
      ST_DIVIDE: state_d = ST_SCAN;
      ST_SCAN: begin
        if ((cnt_q == SCAN_END) && !rd_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = job_slot_i;
    sum_d       = sum_q;
    samp_d      = samp_q;
    slot_d      = slot_q;
    full_d      = full_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_addr_d   = rd_addr_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    dev_d       = dev_q;
    out_valid_d = out_valid_q && out_stall_i;
    o_samp_d    = o_samp_q;
    o_mean_d    = o_mean_q;
    o_cent_d    = o_cent_q;
    o_dev_d     = o_dev_q;
    o_p2p_d     = o_p2p_q;
    case (state_q)
      ST_IDLE: begin
        job_pop_o = job_valid_i;
        samp_d    = job_sample_i;
        slot_d    = job_slot_i;
        full_d    = job_full_i;
      end
      ST_UPDATE: begin
        ram_we = 1'b1;
        sum_d  = sum_q - SUM_W'(old_val) + SUM_W'(samp_q);
      end
      ST_DIVIDE: begin
        quo_d = mean_prod[RECIP_SHIFT +: SAMPLE_W];
        cnt_d = '0;
        hi_d  = '0;
        lo_d  = SAMPLE_MAX;
        dev_d = '0;
      end
      ST_SCAN: begin
        ram_raddr = cnt_q[IDX_W-1:0];
        if (cnt_q != SCAN_END) begin
          rd_vld_d  = 1'b1;
          rd_addr_d = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (scan_diff > dev_q) begin
            dev_d = scan_diff;
          end
          if (scan_val > hi_q) begin
            hi_d = scan_val;
          end
          if (scan_val < lo_q) begin
            lo_d = scan_val;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_samp_d    = samp_q;
          o_mean_d    = quo_q;
          o_cent_d    = {1'b0, samp_q} - {1'b0, quo_q};
          o_dev_d     = dev_q;
          o_p2p_d     = hi_q - lo_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q    <= samp_d;
    slot_q    <= slot_d;
    full_q    <= full_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    rd_addr_q <= rd_addr_d;
    hi_q      <= hi_d;
    lo_q      <= lo_d;
    dev_q     <= dev_d;
    o_samp_q  <= o_samp_d;
    o_mean_q  <= o_mean_d;
    o_cent_q  <= o_cent_d;
    o_dev_q   <= o_dev_d;
    o_p2p_q   <= o_p2p_d;
  end

  assign out_valid_o       = out_valid_q;
  assign newest_sample_o   = o_samp_q;
  assign window_mean_o     = o_mean_q;
  assign centered_sample_o = o_cent_q;
  assign peak_deviation_o  = o_dev_q;
  assign peak_to_peak_o    = o_p2p_q;

endmodule

`default_nettype wire

/* rtl/core/sample_window_mean_and_peak.sv */
// Each sample is processed in order: pop from the queue, update of the ring and sum,
// mean, a scan of the ring through its single read port, and load of the result.
// No new sample is popped until the last result is loaded into the output.
// A two-entry queue takes up to two samples while the engine is busy.
// Reset empties the queue and output; the ring reads as zero until written.
`default_nettype none

module sample_window_mean_and_peak import swmp_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SAMPLE_W-1:0]      newest_sample_o,
  output logic [SAMPLE_W-1:0]      window_mean_o,
  output logic signed [CENT_W-1:0] centered_sample_o,
  output logic [SAMPLE_W-1:0]      peak_deviation_o,
  output logic [SAMPLE_W-1:0]      peak_to_peak_o
);

  localparam int unsigned IDX_W = $clog2(WINDOW_LEN);

  logic                job_valid;
  logic                job_pop;
  logic [SAMPLE_W-1:0] job_sample;
  logic [IDX_W-1:0]    job_slot;
  logic                job_full;

  swmp_front #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop),
    .job_sample_o(job_sample),
    .job_slot_o  (job_slot),
    .job_full_o  (job_full)
  );

  swmp_engine #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_pop_o        (job_pop),
    .job_sample_i     (job_sample),
    .job_slot_i       (job_slot),
    .job_full_i       (job_full),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .newest_sample_o  (newest_sample_o),
    .window_mean_o    (window_mean_o),
    .centered_sample_o(centered_sample_o),
    .peak_deviation_o (peak_deviation_o),
    .peak_to_peak_o   (peak_to_peak_o)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the sample window mean and peak block.
module tb;
  import swmp_pkg::*;

  localparam int unsigned WINDOW_LEN   = 64;
  localparam int unsigned RANDOM_ITEMS = 1430;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      newest;
    logic [SAMPLE_W-1:0]      mean;
    logic signed [CENT_W-1:0] centered;
    logic [SAMPLE_W-1:0]      deviation;
    logic [SAMPLE_W-1:0]      spread;
  } window_stats_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    window_stats_t       stats;
  } directed_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic [SAMPLE_W-1:0]      sample = '0;
  logic                     out_stall = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic [SAMPLE_W-1:0]      newest_sample;
  logic [SAMPLE_W-1:0]      window_mean;
  logic signed [CENT_W-1:0] centered_sample;
  logic [SAMPLE_W-1:0]      peak_deviation;
  logic [SAMPLE_W-1:0]      peak_to_peak;

  logic [SAMPLE_W-1:0] ring_copy [WINDOW_LEN];
  int unsigned         ring_sum;
  int unsigned         ring_head;
  window_stats_t       stats_queue [$];
  int unsigned         mismatch_count = 0;
  bit                  no_idle = 1'b0;
  bit                  long_hold_req = 1'b0;

  directed_row_t directed_rows [21] = '{
    '{10'd0,    1'b1, '{10'd0,    10'd0,  11'sd0,    10'd0,    10'd0}},
    '{10'd1023, 1'b1, '{10'd1023, 10'd15, 11'sd1008, 10'd1008, 10'd1023}},
    '{10'd1023, 1'b1, '{10'd1023, 10'd31, 11'sd992,  10'd992,  10'd1023}},
    '{10'd512,  1'b0, '0},
    '{10'd511,  1'b0, '0},
    '{10'd1,    1'b0, '0},
    '{10'd1022, 1'b0, '0},
    '{10'h2AA,  1'b0, '0},
    '{10'h155,  1'b0, '0},
    '{10'h200,  1'b0, '0},
    '{10'h100,  1'b0, '0},
    '{10'h080,  1'b0, '0},
    '{10'h040,  1'b0, '0},
    '{10'h020,  1'b0, '0},
    '{10'h010,  1'b0, '0},
    '{10'h008,  1'b0, '0},
    '{10'h004,  1'b0, '0},
    '{10'h002,  1'b0, '0},
    '{10'h001,  1'b0, '0},
    '{10'd0,    1'b0, '0},
    '{10'd1023, 1'b0, '0}
  };

  sample_window_mean_and_peak #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .sample_i         (sample),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .newest_sample_o  (newest_sample),
    .window_mean_o    (window_mean),
    .centered_sample_o(centered_sample),
    .peak_deviation_o (peak_deviation),
    .peak_to_peak_o   (peak_to_peak)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic window_stats_t advance_window(input logic [SAMPLE_W-1:0] s);
    window_stats_t r;
    int unsigned   m;
    int unsigned   v;
    int unsigned   d;
    int unsigned   hi;
    int unsigned   lo;
    int unsigned   dev;
    ring_head = (ring_head + 1) % WINDOW_LEN;
    ring_sum = ring_sum - ring_copy[ring_head] + s;
    ring_copy[ring_head] = s;
    m = ring_sum / WINDOW_LEN;
    hi = 0;
    lo = SAMPLE_MAX;
    dev = 0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      v = ring_copy[i];
      d = (v >= m) ? v - m : m - v;
      if (d > dev) dev = d;
      if (v > hi) hi = v;
      if (v < lo) lo = v;
    end
    r.newest = s;
    r.mean = SAMPLE_W'(m);
    r.centered = CENT_W'(int'(s) - int'(m));
    r.deviation = SAMPLE_W'(dev);
    r.spread = SAMPLE_W'(hi - lo);
    return r;
  endfunction

  function automatic void compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("Mismatch in %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input window_stats_t typed_stats);
    window_stats_t predicted;
    repeat (draw_wait()) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predicted = advance_window(s);
    stats_queue.push_back(typed ? typed_stats : predicted);
  endtask

  task automatic send_random_burst(inout int unsigned sent);
    int unsigned         mode;
    int unsigned         len;
    int                  level;
    int                  v;
    logic [SAMPLE_W-1:0] s;
    mode = $urandom_range(0, 9);
    no_idle = ($urandom_range(0, 3) == 0);
    level = $urandom_range(0, SAMPLE_MAX);
    case (mode)
      0, 1, 2: len = $urandom_range(20, 60);
      3, 4:    len = $urandom_range(WINDOW_LEN, WINDOW_LEN + 16);
      5:       len = $urandom_range(WINDOW_LEN, WINDOW_LEN + 6);
      6:       len = $urandom_range(10, 70);
      default: len = $urandom_range(30, 80);
    endcase
    for (int unsigned k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
      case (mode)
        0, 1, 2: s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        3, 4:    s = SAMPLE_MAX;
        5:       s = '0;
        6:       s = k[0] ? SAMPLE_MAX : '0;
        7, 8: begin
          v = level + $urandom_range(0, 16) - 8;
          if (v < 0) v = 0;
          if (v > int'(SAMPLE_MAX)) v = SAMPLE_MAX;
          s = SAMPLE_W'(v);
        end
        default: s = (k == len / 2) ? ($urandom_range(0, 1) ? SAMPLE_MAX : '0)
                                    : SAMPLE_W'(level);
      endcase
      if (sent == 300) long_hold_req = 1'b1;
      send_sample(s, 1'b0, '0);
      sent++;
    end
  endtask

  initial begin
    int unsigned hold_left;
    int unsigned long_left;
    window_stats_t exp_stats;
    hold_left = 0;
    long_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_left = LONG_HOLD;
      end
      if (long_left > 0) begin
        out_stall <= 1'b1;
        long_left--;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        if (stats_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Unexpected result transfer: sample %0d", newest_sample);
        end else begin
          exp_stats = stats_queue.pop_front();
          compare_field("newest_sample", exp_stats.newest, newest_sample);
          compare_field("window_mean", exp_stats.mean, window_mean);
          compare_field("centered_sample", exp_stats.centered, centered_sample);
          compare_field("peak_deviation", exp_stats.deviation, peak_deviation);
          compare_field("peak_to_peak", exp_stats.spread, peak_to_peak);
        end
        hold_left = draw_wait();
      end
    end
  end

  initial begin
    int unsigned sent;
    for (int i = 0; i < WINDOW_LEN; i++) ring_copy[i] = '0;
    ring_sum = 0;
    ring_head = WINDOW_LEN - 1;
    sent = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i])
      send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].stats);
    while (sent < RANDOM_ITEMS) send_random_burst(sent);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (stats_queue.size() != 0) @(posedge clk_i);
    repeat (WINDOW_LEN + 40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
